>>> rtl/prd_pkg.sv
package prd_pkg;

   localparam int ROW_BYTES_W = 13;
   localparam logic [ROW_BYTES_W-1:0] MAX_ROW_BYTES = 13'd4096;
   localparam logic [ROW_BYTES_W-1:0] RESET_ROW_BYTES = 13'd64;

   // Byte codes seen by the run decoder.
   localparam logic [7:0] CONTROL_LIMIT = 8'd128;
   localparam logic [8:0] REPEAT_BASE = 9'd257;
   localparam logic [7:0] END_FILL = 8'h7F;
   localparam logic [7:0] END_RUN_COUNT = 8'd129;

   // What the decoder expects next.
   localparam logic [1:0] EK_CONTROL = 2'd0;
   localparam logic [1:0] EK_LITERAL = 2'd1;
   localparam logic [1:0] EK_REPEAT = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   // CSR map: one register, word index taken from paddr[2].
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_ROW_BYTES = 1'b0;

   typedef struct packed {
      logic       term;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] count;
      logic       done;
      logic       err;
      logic       last;
   } run_type;

endpackage

>>> rtl/prd_front.sv
module prd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        char_in,
   input  logic              terminator,
   input  logic              queue_full,
   output logic              push,
   output prd_pkg::cmd_type  push_cmd
);

   logic       second_half_ff, second_half_in;
   logic [3:0] low_nibble_ff, low_nibble_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      second_half_in = second_half_ff;
      low_nibble_in = low_nibble_ff;
      push = 1'b0;
      push_cmd.term = terminator;
      push_cmd.data = {char_in[3:0], low_nibble_ff};
      if (accept) begin
         if (terminator) begin
            // A pending low nibble is dropped at the end of data.
            push = 1'b1;
            second_half_in = 1'b0;
            low_nibble_in = 4'd0;
         end else if (!second_half_ff) begin
            low_nibble_in = char_in[3:0];
            second_half_in = 1'b1;
         end else begin
            push = 1'b1;
            second_half_in = 1'b0;
            low_nibble_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_half_ff <= 1'b0;
         low_nibble_ff <= 4'd0;
      end else begin
         second_half_ff <= second_half_in;
         low_nibble_ff <= low_nibble_in;
      end
   end

endmodule

>>> rtl/prd_queue.sv
module prd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  prd_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output prd_pkg::cmd_type  pop_cmd
);

   prd_pkg::cmd_type                 entry_ff [prd_pkg::QUEUE_DEPTH];
   logic [prd_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [prd_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [prd_pkg::QUEUE_PTR_W:0]    count_ff, count_in;
   logic                             do_push, do_pop;

   assign full = (count_ff == (prd_pkg::QUEUE_PTR_W+1)'(prd_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/prd_back.sv
module prd_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [prd_pkg::ROW_BYTES_W-1:0]  row_bytes,
   input  logic                             cmd_valid,
   input  prd_pkg::cmd_type                 cmd,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output prd_pkg::run_type                 rsp_run
);

   logic [1:0]                       expect_kind_ff, expect_kind_in;
   logic [7:0]                       run_left_ff, run_left_in;
   logic [prd_pkg::ROW_BYTES_W-1:0]  bytes_filled_ff, bytes_filled_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   prd_pkg::run_type                 rsp_run_ff, rsp_run_in;

   logic [prd_pkg::ROW_BYTES_W-1:0]  row_len, remaining, fill_sum, ctrl_need;
   logic                             out_free, step, pending_run;
   logic                             emit, ctrl_error, over, done, row_end;
   logic [7:0]                       run_value, run_count, inv_byte;
   logic [1:0]                       kind_keep;
   logic [7:0]                       left_keep, left_dec;
   logic [8:0]                       repeat_count;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step = cmd_valid && out_free;

   assign row_len = (row_bytes > prd_pkg::MAX_ROW_BYTES) ? prd_pkg::MAX_ROW_BYTES : row_bytes;
   assign remaining = (bytes_filled_ff < row_len) ? row_len - bytes_filled_ff : '0;
   assign inv_byte = ~cmd.data;
   assign pending_run = (expect_kind_ff == prd_pkg::EK_LITERAL
                         || expect_kind_ff == prd_pkg::EK_REPEAT) && run_left_ff != 8'd0;
   assign left_dec = (run_left_ff != 8'd0) ? run_left_ff - 8'd1 : 8'd0;
   assign repeat_count = prd_pkg::REPEAT_BASE - {1'b0, cmd.data};
   assign ctrl_need = prd_pkg::ROW_BYTES_W'(cmd.data) + 1'b1;

   // Classify the head command: does it make a run, and with what value and count.
   always_comb begin
      emit = 1'b0;
      ctrl_error = 1'b0;
      run_value = inv_byte;
      run_count = 8'd1;
      kind_keep = expect_kind_ff;
      left_keep = run_left_ff;
      if (cmd.term) begin
         // At the end of data every missing byte reads as the end code.
         emit = 1'b1;
         run_value = prd_pkg::END_FILL;
         run_count = pending_run ? run_left_ff : prd_pkg::END_RUN_COUNT;
         kind_keep = prd_pkg::EK_CONTROL;
         left_keep = 8'd0;
      end else begin
         unique case (expect_kind_ff)
            prd_pkg::EK_LITERAL: begin
               emit = 1'b1;
               left_keep = left_dec;
               kind_keep = (left_dec == 8'd0) ? prd_pkg::EK_CONTROL : prd_pkg::EK_LITERAL;
            end
            prd_pkg::EK_REPEAT: begin
               emit = 1'b1;
               run_count = run_left_ff;
               kind_keep = prd_pkg::EK_CONTROL;
               left_keep = 8'd0;
            end
            default: begin
               if (cmd.data < prd_pkg::CONTROL_LIMIT) begin
                  if (ctrl_need > remaining) begin
                     ctrl_error = 1'b1;
                  end else begin
                     kind_keep = prd_pkg::EK_LITERAL;
                     left_keep = cmd.data + 8'd1;
                  end
               end else begin
                  kind_keep = prd_pkg::EK_REPEAT;
                  left_keep = repeat_count[7:0];
               end
            end
         endcase
      end
   end

   assign fill_sum = bytes_filled_ff + prd_pkg::ROW_BYTES_W'(run_count);
   assign over = prd_pkg::ROW_BYTES_W'(run_count) > remaining;
   assign done = !over && (fill_sum == row_len);
   assign row_end = ctrl_error || (emit && (over || done));

   // A terminator stays at the head until its row has ended, one run per cycle while the result register is free.
   assign cmd_pop = step && (!cmd.term || row_end);

   always_comb begin
      expect_kind_in = expect_kind_ff;
      run_left_in = run_left_ff;
      bytes_filled_in = bytes_filled_ff;
      rsp_run_in = rsp_run_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (step) begin
         if (row_end) begin
            expect_kind_in = prd_pkg::EK_CONTROL;
            run_left_in = 8'd0;
            bytes_filled_in = '0;
         end else begin
            expect_kind_in = kind_keep;
            run_left_in = left_keep;
            if (emit) begin
               bytes_filled_in = fill_sum;
            end
         end
         if (emit || ctrl_error) begin
            rsp_valid_in = 1'b1;
            rsp_run_in.err = ctrl_error || over;
            rsp_run_in.done = done && !ctrl_error;
            rsp_run_in.value = (ctrl_error || over) ? 8'd0 : run_value;
            rsp_run_in.count = (ctrl_error || over) ? 8'd0 : run_count;
            rsp_run_in.last = !cmd.term || row_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_kind_ff <= prd_pkg::EK_CONTROL;
         run_left_ff <= 8'd0;
         bytes_filled_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         expect_kind_ff <= expect_kind_in;
         run_left_ff <= run_left_in;
         bytes_filled_ff <= bytes_filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_run_ff <= rsp_run_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_run = rsp_run_ff;

   assert property (@(posedge clock) disable iff (reset)
      bytes_filled_ff <= prd_pkg::MAX_ROW_BYTES)
      else $error("row fill count beyond the largest row");

   assert property (@(posedge clock) disable iff (reset)
      expect_kind_ff == prd_pkg::EK_LITERAL |-> run_left_ff != 8'd0)
      else $error("literal run pending with no bytes left");

   assert property (@(posedge clock) disable iff (reset)
      step && row_end |=> bytes_filled_ff == '0 && expect_kind_ff == prd_pkg::EK_CONTROL)
      else $error("row did not restart after it ended");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_run_ff.done && rsp_run_ff.err))
      else $error("run flagged both complete and in error");

   assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd.term |=> rsp_valid_ff && rsp_run_ff.last)
      else $error("terminator retired without a final run");

endmodule

>>> rtl/packbits_row_decoder.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   tdata char_in, tuser terminator
// rsp_      out        rsp_tvalid/rsp_tready   tdata value/count, tuser flags, tlast
// csr_      in         APB write/read          row_bytes at address 0
//
// The front takes a character whenever the queue is not full; the run decoder takes
// a byte whenever its result register is free. A terminator stays at the head while
// it produces its runs, up to 33 for a 4096-byte row. Two-entry queue between front
// and decoder; the decoder holds while a run waits. Synchronous active-high reset, row_bytes 64.
module packbits_row_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // char_in[7:0]
   input  logic [0:0]                       req_tuser,   // terminator
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [15:0]                      rsp_tdata,   // run_value[7:0], run_count[15:8]
   output logic [1:0]                       rsp_tuser,   // row_done, format_error
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [prd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic [prd_pkg::ROW_BYTES_W-1:0]  row_bytes_ff, row_bytes_in;
   logic                             csr_write;
   logic                             push, queue_full, cmd_valid, cmd_pop;
   prd_pkg::cmd_type                 push_cmd, cmd;
   prd_pkg::run_type                 rsp_run;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr[2] == prd_pkg::CSR_ROW_BYTES);
   assign row_bytes_in = csr_write ? csr_pwdata[prd_pkg::ROW_BYTES_W-1:0] : row_bytes_ff;
   assign csr_prdata = (csr_paddr[2] == prd_pkg::CSR_ROW_BYTES)
                       ? {{(32-prd_pkg::ROW_BYTES_W){1'b0}}, row_bytes_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_bytes_ff <= prd_pkg::RESET_ROW_BYTES;
      end else begin
         row_bytes_ff <= row_bytes_in;
      end
   end

   prd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .char_in    (req_tdata),
      .terminator (req_tuser[0]),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   prd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_cmd   (cmd)
   );

   prd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .row_bytes (row_bytes_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_run   (rsp_run)
   );

   assign rsp_tdata = {rsp_run.count, rsp_run.value};
   assign rsp_tuser = {rsp_run.err, rsp_run.done};
   assign rsp_tlast = rsp_run.last;

endmodule
